>>> src/node_allocator_with_mark_collect_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the node allocator
// Concurrent assertion wrappers on i_clk, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef NODE_ALLOCATOR_WITH_MARK_COLLECT_DEFINES_SVH
`define NODE_ALLOCATOR_WITH_MARK_COLLECT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked outside reset.
`define NAMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define NAMC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define NAMC_ASSERT(label, prop, msg)
`define NAMC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> src/namc_pkg.sv
// ----------------------------------------------------------------------------
// namc_pkg
// Types and constants shared by the node allocator modules.
// ----------------------------------------------------------------------------
package namc_pkg;

    localparam int NODE_COUNT = 256;
    localparam int NODE_W     = 8;
    localparam int SP_W       = $clog2(NODE_COUNT + 1);
    localparam int SCAN_LOG   = 4;
    localparam int SCAN_W     = 1 << SCAN_LOG;
    localparam int SCAN_WORDS = NODE_COUNT / SCAN_W;
    localparam int WORD_W     = $clog2(SCAN_WORDS);
    localparam int NODE_DATA_W = 1 + 2 * NODE_W;

    localparam logic [2:0] FN_ALLOC      = 3'd0;
    localparam logic [2:0] FN_ALLOC_ROOT = 3'd1;
    localparam logic [2:0] FN_ADD_ROOT   = 3'd2;
    localparam logic [2:0] FN_DEL_ROOT   = 3'd3;
    localparam logic [2:0] FN_QUERY_ROOT = 3'd4;
    localparam logic [2:0] FN_WRITE_NODE = 3'd5;
    localparam logic [2:0] FN_COLLECT    = 3'd6;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ROOTS_FULL = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
    localparam logic [1:0] ST_NO_MEMORY  = 2'd3;

    typedef struct packed {
        logic [2:0]        func;
        logic [NODE_W-1:0] node_id;
        logic              is_list;
        logic [NODE_W-1:0] first_link;
        logic [NODE_W-1:0] second_link;
    } t_req;

    typedef struct packed {
        logic [NODE_W-1:0] result_node;
        logic              root_flag;
        logic [1:0]        status;
    } t_rsp;

endpackage

>>> src/namc_ram.sv
// ----------------------------------------------------------------------------
// namc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module namc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/node_allocator_with_mark_collect.sv
// ----------------------------------------------------------------------------
// node_allocator_with_mark_collect
// Cons node allocator with root table and stack-based mark collection.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                  | Payload
//  request  | in        | i_req_valid / o_req_stall  | i_req (t_req)
//  response | out       | o_rsp_valid / i_rsp_stall  | o_rsp (t_rsp)
//
// Root table operations, node writes and the unused code pass through EXEC
// and RESP to the response register. An allocation scans the in-use bits
// sixteen at a time; if no node is free it runs one collection and scans again.
// A collection runs through the node and stack RAMs: CLEAR clears the in-use
// bits, ROOT visits each root slot in turn, and each root that starts a walk
// pops marked nodes through POP, POPW and NODEW; list nodes then also pass
// through PUSHL and PUSHR.
// Reset is synchronous and clears the in-use bits and the root table.
// A request is taken while a response still waits; the next response then
// waits in turn until the response register is free.
// ----------------------------------------------------------------------------
module node_allocator_with_mark_collect #(
    parameter int ROOT_SLOTS = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  namc_pkg::t_req  i_req,
    output logic            o_req_stall,
    output logic            o_rsp_valid,
    output namc_pkg::t_rsp  o_rsp,
    input  logic            i_rsp_stall
);

    import namc_pkg::*;

`include "node_allocator_with_mark_collect_defines.svh"

    localparam int RI_W   = $clog2(ROOT_SLOTS + 1);
    localparam int SLOT_W = (ROOT_SLOTS > 1) ? $clog2(ROOT_SLOTS) : 1;

    // Sequencer states. The mark pass runs through ROOT, POP, POPW, NODEW
    // and the two push states.
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_EXEC  = 11'b000_0000_0010,
        S_SCAN  = 11'b000_0000_0100,
        S_CLEAR = 11'b000_0000_1000,
        S_ROOT  = 11'b000_0001_0000,
        S_POP   = 11'b000_0010_0000,
        S_POPW  = 11'b000_0100_0000,
        S_NODEW = 11'b000_1000_0000,
        S_PUSHL = 11'b001_0000_0000,
        S_PUSHR = 11'b010_0000_0000,
        S_RESP  = 11'b100_0000_0000
    } t_state;

    t_state                  r_state, n_state;
    t_req                    r_req, n_req;
    logic [WORD_W-1:0]       r_w, n_w;
    logic                    r_gc_done, n_gc_done;
    logic [RI_W-1:0]         r_ri, n_ri;
    logic [SP_W-1:0]         r_sp, n_sp;
    logic [NODE_W-1:0]       r_left, n_left;
    logic [NODE_W-1:0]       r_right, n_right;
    logic [NODE_COUNT-1:0]   r_used, n_used;
    logic [ROOT_SLOTS-1:0]   r_rvalid, n_rvalid;
    logic [NODE_W-1:0]       r_rindex [ROOT_SLOTS];
    logic [NODE_W-1:0]       n_rindex [ROOT_SLOTS];
    t_rsp                    r_res, n_res;
    t_rsp                    r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    // Root table lookups: lowest empty slot and lowest slot matching node_id.
    logic              empty_found, match_found;
    logic [SLOT_W-1:0] empty_slot, match_slot;

    always_comb begin
        empty_found = 1'b0;
        match_found = 1'b0;
        empty_slot  = '0;
        match_slot  = '0;
        for (int i = ROOT_SLOTS - 1; i >= 0; i--) begin
            if (!r_rvalid[i]) begin
                empty_found = 1'b1;
                empty_slot  = SLOT_W'(i);
            end
            if (r_rvalid[i] && (r_rindex[i] == r_req.node_id)) begin
                match_found = 1'b1;
                match_slot  = SLOT_W'(i);
            end
        end
    end

    // Free search over one sixteen-bit word of in-use bits per cycle.
    logic [SCAN_W-1:0]   scan_bits;
    logic                word_free;
    logic [SCAN_LOG-1:0] free_pos;
    logic [NODE_W-1:0]   free_node;

    assign scan_bits = r_used[{r_w, {SCAN_LOG{1'b0}}} +: SCAN_W];

    always_comb begin
        word_free = 1'b0;
        free_pos  = '0;
        for (int b = SCAN_W - 1; b >= 0; b--) begin
            if (!scan_bits[b]) begin
                word_free = 1'b1;
                free_pos  = SCAN_LOG'(b);
            end
        end
    end

    assign free_node = {r_w, free_pos};

    // Mark stack and node store.
    logic                   stk_we;
    logic [NODE_W-1:0]      stk_wdata;
    logic [NODE_W-1:0]      stk_rdata;
    logic [SP_W-1:0]        sp_dec;
    logic                   node_we;
    logic [NODE_DATA_W-1:0] node_rdata;

    assign sp_dec = r_sp - 1'b1;

    namc_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_sp[NODE_W-1:0]),
        .i_wdata (stk_wdata),
        .i_raddr (sp_dec[NODE_W-1:0]),
        .o_rdata (stk_rdata)
    );

    namc_ram #(
        .WIDTH (NODE_DATA_W),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (r_req.node_id),
        .i_wdata ({r_req.is_list, r_req.first_link, r_req.second_link}),
        .i_raddr (stk_rdata),
        .o_rdata (node_rdata)
    );

    // Current root during the mark pass.
    logic [SLOT_W-1:0] cur_slot;
    logic              roots_done;
    logic [NODE_W-1:0] cur_root;

    assign cur_slot   = r_ri[SLOT_W-1:0];
    assign roots_done = (r_ri == RI_W'(ROOT_SLOTS));
    assign cur_root   = r_rindex[cur_slot];

    logic is_alloc;
    assign is_alloc = (r_req.func == FN_ALLOC) || (r_req.func == FN_ALLOC_ROOT);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_w         = r_w;
        n_gc_done   = r_gc_done;
        n_ri        = r_ri;
        n_sp        = r_sp;
        n_left      = r_left;
        n_right     = r_right;
        n_used      = r_used;
        n_rvalid    = r_rvalid;
        n_rindex    = r_rindex;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        stk_we      = 1'b0;
        stk_wdata   = '0;
        node_we     = 1'b0;

        if (r_out_valid && !i_rsp_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = '0;
                n_state = S_RESP;
                case (r_req.func) inside
                    FN_ALLOC, FN_ALLOC_ROOT: begin
                        n_w       = '0;
                        n_gc_done = 1'b0;
                        n_state   = S_SCAN;
                    end
                    FN_ADD_ROOT: begin
                        if (empty_found) begin
                            n_rvalid[empty_slot] = 1'b1;
                            n_rindex[empty_slot] = r_req.node_id;
                        end else begin
                            n_res.status = ST_ROOTS_FULL;
                        end
                    end
                    FN_DEL_ROOT: begin
                        if (match_found) begin
                            n_rvalid[match_slot] = 1'b0;
                        end else begin
                            n_res.status = ST_NOT_FOUND;
                        end
                    end
                    FN_QUERY_ROOT: begin
                        n_res.root_flag = match_found;
                    end
                    FN_WRITE_NODE: begin
                        node_we = 1'b1;
                    end
                    FN_COLLECT: begin
                        n_state = S_CLEAR;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (word_free) begin
                    n_state = S_RESP;
                    if ((r_req.func == FN_ALLOC_ROOT) && !empty_found) begin
                        n_res.status = ST_ROOTS_FULL;
                    end else begin
                        if (r_req.func == FN_ALLOC_ROOT) begin
                            n_rvalid[empty_slot] = 1'b1;
                            n_rindex[empty_slot] = free_node;
                        end
                        n_used[free_node] = 1'b1;
                        n_res.result_node = free_node;
                    end
                end else if (&r_w) begin
                    if (!r_gc_done) begin
                        n_gc_done = 1'b1;
                        n_state   = S_CLEAR;
                    end else begin
                        n_res.status = ST_NO_MEMORY;
                        n_state      = S_RESP;
                    end
                end else begin
                    n_w = r_w + 1'b1;
                end
            end
            S_CLEAR: begin
                n_used  = '0;
                n_sp    = '0;
                n_ri    = '0;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (roots_done) begin
                    if (is_alloc) begin
                        n_w     = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RESP;
                    end
                end else begin
                    n_ri = r_ri + 1'b1;
                    if (r_rvalid[cur_slot] && !r_used[cur_root]) begin
                        stk_we           = 1'b1;
                        stk_wdata        = cur_root;
                        n_used[cur_root] = 1'b1;
                        n_sp             = r_sp + 1'b1;
                        n_state          = S_POP;
                    end
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_state = S_ROOT;
                end else begin
                    n_sp    = sp_dec;
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_state = S_NODEW;
            end
            S_NODEW: begin
                n_left  = node_rdata[2*NODE_W-1:NODE_W];
                n_right = node_rdata[NODE_W-1:0];
                n_state = node_rdata[NODE_DATA_W-1] ? S_PUSHL : S_POP;
            end
            S_PUSHL: begin
                if (!r_used[r_left]) begin
                    stk_we         = 1'b1;
                    stk_wdata      = r_left;
                    n_used[r_left] = 1'b1;
                    n_sp           = r_sp + 1'b1;
                end
                n_state = S_PUSHR;
            end
            S_PUSHR: begin
                if (!r_used[r_right]) begin
                    stk_we          = 1'b1;
                    stk_wdata       = r_right;
                    n_used[r_right] = 1'b1;
                    n_sp            = r_sp + 1'b1;
                end
                n_state = S_POP;
            end
            S_RESP: begin
                if (!r_out_valid || !i_rsp_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_rvalid    <= '0;
            r_out_valid <= 1'b0;
            r_sp        <= '0;
            r_ri        <= '0;
            r_w         <= '0;
            r_gc_done   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_rvalid    <= n_rvalid;
            r_out_valid <= n_out_valid;
            r_sp        <= n_sp;
            r_ri        <= n_ri;
            r_w         <= n_w;
            r_gc_done   <= n_gc_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_left   <= n_left;
        r_right  <= n_right;
        r_rindex <= n_rindex;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // The stack never holds more entries than there are nodes.
    `NAMC_ASSERT(a_sp_bound, (r_sp <= SP_W'(NODE_COUNT)), "mark stack overflow")
    // A new root is only started with an empty stack.
    `NAMC_ASSERT(a_root_empty_stack, (r_state == S_ROOT) |-> (r_sp == '0), "stack not empty")
    // A pop takes exactly one entry off the stack.
    `NAMC_ASSERT(a_pop_dec, (r_state == S_POP) && (r_sp != '0) |=> (r_sp == $past(sp_dec)),
        "bad pop")
    // A response that may leave the sequencer reaches the output register.
    `NAMC_ASSERT(a_resp_out, (r_state == S_RESP) && !(r_out_valid && i_rsp_stall) |=> r_out_valid,
        "response lost")

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the node allocator against a predictor of its node and root tables.
// ----------------------------------------------------------------------------
module tb;
    import namc_pkg::*;

    localparam int SLOTS     = 10;
    localparam int MAX_CYC   = 10000000;
    localparam int RAND_REQS = 200;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    t_req i_req;
    logic o_req_stall;
    logic o_rsp_valid;
    t_rsp o_rsp;
    logic i_rsp_stall;

    node_allocator_with_mark_collect #(.ROOT_SLOTS(SLOTS)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_rsp_stall (i_rsp_stall)
    );

    // Shadow copy of the block's tables. The written bits record which nodes
    // have had their type and links set, so that a collection is never
    // issued while it would read a node that was never written.
    bit         in_use  [NODE_COUNT];
    bit         is_pair [NODE_COUNT];
    logic [7:0] left_of [NODE_COUNT];
    logic [7:0] right_of[NODE_COUNT];
    bit         written [NODE_COUNT];
    bit         slot_ok [SLOTS];
    logic [7:0] slot_id [SLOTS];

    t_rsp rsp_due[$];
    int   cycles;
    int   mismatches;
    bit   quiet;
    int   stall_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall watchdog; the slowest legal run is far below this figure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("[node_allocator_with_mark_collect] ERROR");
            $finish;
        end
    end

    // Marks every node reachable from the valid root slots, following the
    // links of list nodes only. Already-marked nodes are never pushed again.
    function automatic void mark_pass(output bit mk[NODE_COUNT]);
        logic [7:0] stk[NODE_COUNT];
        int sp;
        int n;
        mk = '{default: 1'b0};
        sp = 0;
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_ok[s] && !mk[slot_id[s]]) begin
                mk[slot_id[s]] = 1'b1;
                stk[sp] = slot_id[s];
                sp++;
            end
            while (sp > 0) begin
                sp--;
                n = stk[sp];
                if (is_pair[n]) begin
                    if (!mk[left_of[n]]) begin
                        mk[left_of[n]] = 1'b1;
                        stk[sp] = left_of[n];
                        sp++;
                    end
                    if (!mk[right_of[n]]) begin
                        mk[right_of[n]] = 1'b1;
                        stk[sp] = right_of[n];
                        sp++;
                    end
                end
            end
        end
    endfunction

    function automatic int lowest_free();
        for (int i = 0; i < NODE_COUNT; i++)
            if (!in_use[i]) return i;
        return -1;
    endfunction

    function automatic int empty_slot();
        for (int s = 0; s < SLOTS; s++)
            if (!slot_ok[s]) return s;
        return -1;
    endfunction

    // First reachable node that was never written, or -1 when a collection
    // now would only read defined nodes.
    function automatic int unwritten_reachable();
        bit mk[NODE_COUNT];
        mark_pass(mk);
        for (int i = 0; i < NODE_COUNT; i++)
            if (mk[i] && !written[i]) return i;
        return -1;
    endfunction

    function automatic bit will_collect(t_req r);
        return (r.func == FN_COLLECT) ||
               ((r.func == FN_ALLOC || r.func == FN_ALLOC_ROOT) && lowest_free() < 0);
    endfunction

    // Applies one request to the shadow tables and returns its response.
    function automatic t_rsp apply_request(t_req r);
        t_rsp o;
        int   n;
        int   s;
        o = '0;
        o.status = ST_OK;
        case (r.func)
            FN_ALLOC, FN_ALLOC_ROOT: begin
                n = lowest_free();
                if (n < 0) begin
                    mark_pass(in_use);
                    n = lowest_free();
                end
                if (n < 0) begin
                    o.status = ST_NO_MEMORY;
                end else begin
                    s = empty_slot();
                    if (r.func == FN_ALLOC_ROOT && s < 0) begin
                        o.status = ST_ROOTS_FULL;
                    end else begin
                        if (r.func == FN_ALLOC_ROOT) begin
                            slot_ok[s] = 1'b1;
                            slot_id[s] = n[7:0];
                        end
                        in_use[n] = 1'b1;
                        o.result_node = n[7:0];
                    end
                end
            end
            FN_ADD_ROOT: begin
                s = empty_slot();
                if (s < 0) begin
                    o.status = ST_ROOTS_FULL;
                end else begin
                    slot_ok[s] = 1'b1;
                    slot_id[s] = r.node_id;
                end
            end
            FN_DEL_ROOT: begin
                o.status = ST_NOT_FOUND;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_ok[i] && slot_id[i] == r.node_id) begin
                        slot_ok[i] = 1'b0;
                        o.status = ST_OK;
                        break;
                    end
                end
            end
            FN_QUERY_ROOT: begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_ok[i] && slot_id[i] == r.node_id) o.root_flag = 1'b1;
            end
            FN_WRITE_NODE: begin
                is_pair[r.node_id]  = r.is_list;
                left_of[r.node_id]  = r.first_link;
                right_of[r.node_id] = r.second_link;
                written[r.node_id]  = 1'b1;
            end
            FN_COLLECT: mark_pass(in_use);
            default: ;
        endcase
        return o;
    endfunction

    // Issues one request. The predicted response is queued first, unless a
    // typed-in response is supplied, in which case that one is queued.
    task automatic issue(t_req r, bit typed, t_rsp typed_rsp);
        t_rsp p;
        int   gap;
        p = apply_request(r);
        rsp_due.push_back(typed ? typed_rsp : p);
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req       <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (o_req_stall);
    endtask

    task automatic issue_write(logic [7:0] id, bit pair, logic [7:0] l, logic [7:0] rt);
        t_req r;
        r = '{FN_WRITE_NODE, id, pair, l, rt};
        issue(r, 1'b0, '0);
    endtask

    // Before any request that would collect, every reachable node is given a
    // type and links; children of these repair writes point at written nodes.
    task automatic issue_safe(t_req r);
        int b;
        logic [7:0] l;
        logic [7:0] rt;
        b = unwritten_reachable();
        while (will_collect(r) && b >= 0) begin
            l  = 8'($urandom_range(0, 255));
            rt = 8'($urandom_range(0, 255));
            if (!written[l])  l  = b[7:0];
            if (!written[rt]) rt = b[7:0];
            issue_write(b[7:0], 1'($urandom_range(0, 1)), l, rt);
            b = unwritten_reachable();
        end
        issue(r, 1'b0, '0);
    endtask

    function automatic t_req random_request();
        t_req r;
        int   k;
        r = '0;
        r.node_id     = 8'($urandom_range(0, 255));
        r.first_link  = 8'($urandom_range(0, 255));
        r.second_link = 8'($urandom_range(0, 255));
        r.is_list     = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 99);
        if (k < 45)      r.func = FN_ALLOC;
        else if (k < 53) r.func = FN_ALLOC_ROOT;
        else if (k < 63) r.func = FN_ADD_ROOT;
        else if (k < 75) r.func = FN_DEL_ROOT;
        else if (k < 82) r.func = FN_QUERY_ROOT;
        else if (k < 94) r.func = FN_WRITE_NODE;
        else if (k < 98) r.func = FN_COLLECT;
        else             r.func = 3'd7;
        // Deletes and queries mostly name a live root so that they hit.
        if ((r.func == FN_DEL_ROOT || r.func == FN_QUERY_ROOT) &&
            $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, SLOTS - 1);
            if (slot_ok[k]) r.node_id = slot_id[k];
        end
        return r;
    endfunction

    // Response side: random stalls, and a comparison with the oldest
    // expectation on every accepted response.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left  = 0;
            i_rsp_stall <= 1'b0;
        end else begin
            if (o_rsp_valid && !i_rsp_stall) begin
                if (rsp_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response %p", o_rsp);
                end else begin
                    if (o_rsp !== rsp_due[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response mismatch: node exp %0d got %0d,",
                                     rsp_due[0].result_node, o_rsp.result_node,
                                     " flag exp %0b got %0b,",
                                     rsp_due[0].root_flag, o_rsp.root_flag,
                                     " status exp %0d got %0d",
                                     rsp_due[0].status, o_rsp.status);
                    end
                    void'(rsp_due.pop_front());
                end
                stall_left = quiet ? 0 : $urandom_range(0, 8);
            end
            i_rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    typedef struct {
        t_req r;
        bit   typed;
        t_rsp exp_rsp;
    } t_row;

    t_row rows[$];

    function automatic void add_row(logic [2:0] f, logic [7:0] id, bit lst,
                                    logic [7:0] l, logic [7:0] rt,
                                    bit typed, logic [7:0] node, bit flag, logic [1:0] st);
        t_row w;
        w.r       = '{f, id, lst, l, rt};
        w.typed   = typed;
        w.exp_rsp = '{node, flag, st};
        rows.push_back(w);
    endfunction

    initial begin
        int   got;
        int   waited;
        t_rsp p;
        quiet       = 1'b0;
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        in_use  = '{default: 1'b0};
        is_pair = '{default: 1'b0};
        left_of = '{default: '0};
        right_of = '{default: '0};
        written = '{default: 1'b0};
        slot_ok = '{default: 1'b0};
        slot_id = '{default: '0};

        // Directed part: behaviour after reset, extremes of the fields, the
        // unused code, duplicate roots and a full root table.
        add_row(FN_QUERY_ROOT, 8'd0,   0, 8'd0,   8'd0,   1, 8'd0, 0, ST_OK);
        add_row(FN_DEL_ROOT,   8'd255, 0, 8'd0,   8'd0,   1, 8'd0, 0, ST_NOT_FOUND);
        add_row(3'd7,          8'd255, 1, 8'd255, 8'd255, 1, 8'd0, 0, ST_OK);
        add_row(FN_WRITE_NODE, 8'd0,   0, 8'd255, 8'd255, 1, 8'd0, 0, ST_OK);
        add_row(FN_WRITE_NODE, 8'd255, 1, 8'd0,   8'd255, 1, 8'd0, 0, ST_OK);
        add_row(FN_WRITE_NODE, 8'd1,   1, 8'd1,   8'd0,   1, 8'd0, 0, ST_OK);
        add_row(FN_ALLOC,      8'd0,   0, 8'd0,   8'd0,   1, 8'd0, 0, ST_OK);
        add_row(FN_ALLOC_ROOT, 8'd0,   0, 8'd0,   8'd0,   1, 8'd1, 0, ST_OK);
        add_row(FN_ADD_ROOT,   8'd255, 0, 8'd0,   8'd0,   1, 8'd0, 0, ST_OK);
        add_row(FN_ADD_ROOT,   8'd255, 0, 8'd0,   8'd0,   1, 8'd0, 0, ST_OK);
        add_row(FN_QUERY_ROOT, 8'd255, 0, 8'd0,   8'd0,   1, 8'd0, 1, ST_OK);
        add_row(FN_DEL_ROOT,   8'd255, 0, 8'd0,   8'd0,   1, 8'd0, 0, ST_OK);
        add_row(FN_QUERY_ROOT, 8'd255, 0, 8'd0,   8'd0,   1, 8'd0, 1, ST_OK);
        for (int i = 0; i < 8; i++)
            add_row(FN_ADD_ROOT, 8'd0, 0, 8'd0, 8'd0, 1, 8'd0, 0, ST_OK);
        add_row(FN_ADD_ROOT,   8'd0,   0, 8'd0,   8'd0,   1, 8'd0, 0, ST_ROOTS_FULL);
        add_row(FN_ALLOC_ROOT, 8'd0,   0, 8'd0,   8'd0,   1, 8'd0, 0, ST_ROOTS_FULL);
        add_row(FN_COLLECT,    8'd0,   0, 8'd0,   8'd0,   0, 8'd0, 0, ST_OK);
        add_row(FN_ALLOC,      8'd0,   0, 8'd0,   8'd0,   0, 8'd0, 0, ST_OK);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            issue(rows[i].r, rows[i].typed, rows[i].exp_rsp);

        // Random part, with stretches where neither side holds back.
        for (int i = 0; i < RAND_REQS; i++) begin
            if (i % 80 == 0) quiet = ($urandom_range(0, 2) == 0);
            issue_safe(random_request());
        end

        // Exhaust the memory: one long chain of list nodes hung from a single
        // root keeps every node live, so allocation ends out of memory.
        quiet = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_ok[i]) issue_safe('{FN_DEL_ROOT, slot_id[i], 1'b0, 8'd0, 8'd0});
        for (int i = 0; i < NODE_COUNT; i++)
            issue_write(i[7:0], i < NODE_COUNT - 1, i[7:0] + 8'd1, i[7:0] + 8'd1);
        issue_safe('{FN_ADD_ROOT, 8'd0, 1'b0, 8'd0, 8'd0});
        got = 0;
        while (got < NODE_COUNT + 2) begin
            issue_safe('{FN_ALLOC, 8'd0, 1'b0, 8'd0, 8'd0});
            got++;
            if (lowest_free() < 0 && unwritten_reachable() < 0) begin
                p = apply_request('{FN_QUERY_ROOT, 8'd0, 1'b0, 8'd0, 8'd0});
                if (p.root_flag) begin
                    issue_safe('{FN_ALLOC, 8'd0, 1'b0, 8'd0, 8'd0});
                    break;
                end
            end
        end
        issue_safe('{FN_ALLOC_ROOT, 8'd0, 1'b0, 8'd0, 8'd0});
        issue_safe('{FN_DEL_ROOT, 8'd0, 1'b0, 8'd0, 8'd0});
        issue_safe('{FN_ALLOC, 8'd0, 1'b0, 8'd0, 8'd0});
        i_req_valid <= 1'b0;

        waited = 0;
        while (rsp_due.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && rsp_due.size() == 0) begin
            $display("[node_allocator_with_mark_collect] OK");
        end else begin
            $display("[node_allocator_with_mark_collect] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/namc_pkg.sv
src/namc_ram.sv
src/node_allocator_with_mark_collect.sv
bench/tb.sv
